// ----- rtl/i2cmbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and codes of the i2c master byte engine: request types,
// operation and status codes, sequencer phases, engine state and result.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    // request type codes
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_LINES = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    // active byte operation
    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_RSVD  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // completion status
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_SCL = 2'd1,
        ST_BUSY   = 2'd2,
        ST_RSVD   = 2'd3
    } t_status;

    localparam int PHASE_W = 5;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_BITS_END = 5'd16;
    localparam logic [PHASE_W-1:0] PH_LAST_BIT = 5'd15;
    localparam logic [PHASE_W-1:0] PH_ACK_HI   = 5'd16;
    localparam logic [PHASE_W-1:0] PH_ACK_LO   = 5'd17;
    localparam logic [PHASE_W-1:0] PH_DONE     = 5'd18;

    // line field bit positions
    localparam int LINE_SCL = 0;
    localparam int LINE_SDA = 1;

    // engine state
    typedef struct packed {
        logic               scl_on;
        logic               scl_high;
        logic               sda_on;
        logic               sda_high;
        logic               ack_known;
        logic               ack_high;
        logic [PHASE_W-1:0] phase;
        t_op                active_op;
        logic [7:0]         shift_byte;
        logic               final_byte;
        logic               ack_seen;
    } t_state;

    // one result item
    typedef struct packed {
        logic       scl_drive_en;
        logic       scl_out_level;
        logic       sda_drive_en;
        logic       sda_out_level;
        logic       done_res;
        t_status    status;
        logic [7:0] read_data;
        logic       ack_received;
    } t_result;

    // one request item
    typedef struct packed {
        t_req       req_type;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [1:0] line_value;
        logic [1:0] line_direction;
        logic       sda_in;
    } t_request;

endpackage

// ----- rtl/i2c_master_byte_engine_unit.sv -----
`timescale 1ns / 1ps
// Latency: a request's result is shown in the cycle after the request is taken.
// Throughput: one request per cycle while the result side does not stall; one sequencer step per request.
// A request is taken whenever the result register is empty or being read.
// Reset (synchronous, active low): lines released, SCL and SDA levels high,
// engine idle, no result pending.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// Open-drain i2c master byte engine paced by half-period tick requests.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic [1:0] i_line_value,
    input  logic [1:0] i_line_direction,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_scl_drive_en,
    output logic       o_scl_out_level,
    output logic       o_sda_drive_en,
    output logic       o_sda_out_level,
    output logic       o_done_res,
    output logic [1:0] o_status,
    output logic [7:0] o_read_data,
    output logic       o_ack_received
);

    i2cmbe_pkg::t_state   r_state;
    i2cmbe_pkg::t_state   n_state;
    i2cmbe_pkg::t_request req;
    i2cmbe_pkg::t_result  step_result;
    i2cmbe_pkg::t_result  out_result;
    logic                 can_load;
    logic                 accept;

    assign accept  = i_valid & can_load;
    assign o_ready = can_load;

    // request bundle
    always_comb begin
        req.req_type       = i2cmbe_pkg::t_req'(i_req_type);
        req.data_byte      = i_data_byte;
        req.last_byte      = i_last_byte;
        req.line_value     = i_line_value;
        req.line_direction = i_line_direction;
        req.sda_in         = i_sda_in;
    end

    i2cmbe_step u_step (
        .i_state  (r_state),
        .i_req    (req),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.scl_on     <= 1'b0;
            r_state.scl_high   <= 1'b1;
            r_state.sda_on     <= 1'b0;
            r_state.sda_high   <= 1'b1;
            r_state.ack_known  <= 1'b0;
            r_state.ack_high   <= 1'b1;
            r_state.phase      <= '0;
            r_state.active_op  <= i2cmbe_pkg::OP_IDLE;
            r_state.shift_byte <= 8'd0;
            r_state.final_byte <= 1'b0;
            r_state.ack_seen   <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    i2cmbe_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (step_result),
        .i_ready    (i_ready),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .o_result   (out_result)
    );

    assign o_scl_drive_en  = out_result.scl_drive_en;
    assign o_scl_out_level = out_result.scl_out_level;
    assign o_sda_drive_en  = out_result.sda_drive_en;
    assign o_sda_out_level = out_result.sda_out_level;
    assign o_done_res      = out_result.done_res;
    assign o_status        = out_result.status;
    assign o_read_data     = out_result.read_data;
    assign o_ack_received  = out_result.ack_received;

endmodule

// ----- rtl/i2cmbe_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_step
// Next-state and result logic for one request: a single sequencer step
// of the byte engine.
// ----------------------------------------------------------------------------
module i2cmbe_step (
    input  i2cmbe_pkg::t_state   i_state,
    input  i2cmbe_pkg::t_request i_req,
    output i2cmbe_pkg::t_state   o_state,
    output i2cmbe_pkg::t_result  o_result
);

    i2cmbe_pkg::t_state  n_st;
    logic                done;
    i2cmbe_pkg::t_status status;
    logic [7:0]          rd;
    logic                ak;
    logic                busy;

    assign busy = (i_state.active_op != i2cmbe_pkg::OP_IDLE);

    // state update for one request
    always_comb begin
        n_st   = i_state;
        done   = 1'b0;
        status = i2cmbe_pkg::ST_OK;
        rd     = 8'd0;
        ak     = 1'b0;
        unique case (i_req.req_type)
            i2cmbe_pkg::REQ_TICK: begin
                if (busy) begin
                    if (i_state.phase < i2cmbe_pkg::PH_BITS_END) begin
                        if (!i_state.phase[0]) begin
                            n_st.scl_high = 1'b1;
                        end else begin
                            if (i_state.active_op == i2cmbe_pkg::OP_READ) begin
                                n_st.shift_byte = {i_state.shift_byte[6:0], i_req.sda_in};
                            end else if (i_state.phase < i2cmbe_pkg::PH_LAST_BIT) begin
                                n_st.shift_byte = {i_state.shift_byte[6:0], 1'b0};
                                if (i_state.sda_on) begin
                                    n_st.sda_high = i_state.shift_byte[6];
                                end
                            end
                            n_st.scl_high = 1'b0;
                        end
                        n_st.phase = i_state.phase + 1'b1;
                    end else if (i_state.phase == i2cmbe_pkg::PH_ACK_HI) begin
                        n_st.scl_high = 1'b1;
                        n_st.phase    = i2cmbe_pkg::PH_ACK_LO;
                    end else if (i_state.phase == i2cmbe_pkg::PH_ACK_LO) begin
                        if (i_state.active_op == i2cmbe_pkg::OP_WRITE) begin
                            n_st.ack_seen = ~i_req.sda_in;
                        end
                        n_st.scl_high = 1'b0;
                        n_st.phase    = i2cmbe_pkg::PH_DONE;
                    end else begin
                        // restore ack preference and complete
                        n_st.ack_known = i_state.sda_on;
                        n_st.ack_high  = i_state.sda_high;
                        done           = 1'b1;
                        if (i_state.active_op == i2cmbe_pkg::OP_READ) begin
                            rd = i_state.shift_byte;
                        end else begin
                            ak = i_state.ack_seen;
                        end
                        n_st.active_op = i2cmbe_pkg::OP_IDLE;
                        n_st.phase     = '0;
                    end
                end
            end
            i2cmbe_pkg::REQ_LINES: begin
                if (busy) begin
                    status = i2cmbe_pkg::ST_BUSY;
                end else begin
                    n_st.scl_on    = i_req.line_direction[i2cmbe_pkg::LINE_SCL];
                    n_st.scl_high  = i_req.line_value[i2cmbe_pkg::LINE_SCL];
                    n_st.sda_on    = i_req.line_direction[i2cmbe_pkg::LINE_SDA];
                    n_st.sda_high  = i_req.line_value[i2cmbe_pkg::LINE_SDA];
                    n_st.ack_known = i_req.line_direction[i2cmbe_pkg::LINE_SDA];
                    n_st.ack_high  = i_req.line_value[i2cmbe_pkg::LINE_SDA];
                end
            end
            default: begin
                // byte commands
                if (busy) begin
                    done   = 1'b1;
                    status = i2cmbe_pkg::ST_BUSY;
                end else if (!i_state.scl_on) begin
                    done   = 1'b1;
                    status = i2cmbe_pkg::ST_NO_SCL;
                end else if (i_req.req_type == i2cmbe_pkg::REQ_WRITE) begin
                    n_st.active_op  = i2cmbe_pkg::OP_WRITE;
                    n_st.phase      = '0;
                    n_st.shift_byte = i_req.data_byte;
                    n_st.ack_seen   = 1'b0;
                    if (i_state.sda_on) begin
                        n_st.sda_high = i_req.data_byte[7];
                    end
                end else begin
                    n_st.active_op  = i2cmbe_pkg::OP_READ;
                    n_st.phase      = '0;
                    n_st.shift_byte = 8'd0;
                    n_st.final_byte = i_req.last_byte;
                end
            end
        endcase
    end

    // line outputs from the updated state
    always_comb begin
        o_result.scl_drive_en  = n_st.scl_on;
        o_result.scl_out_level = n_st.scl_high;
        o_result.sda_drive_en  = n_st.sda_on;
        o_result.sda_out_level = n_st.sda_high;
        if (n_st.active_op == i2cmbe_pkg::OP_WRITE && n_st.phase >= i2cmbe_pkg::PH_BITS_END) begin
            o_result.sda_drive_en  = 1'b0;
            o_result.sda_out_level = 1'b1;
        end else if (n_st.active_op == i2cmbe_pkg::OP_READ) begin
            if (n_st.phase < i2cmbe_pkg::PH_BITS_END) begin
                o_result.sda_drive_en  = 1'b0;
                o_result.sda_out_level = 1'b1;
            end else begin
                // ack on middle bytes, stored preference or nack on the last
                o_result.sda_drive_en  = 1'b1;
                o_result.sda_out_level = n_st.final_byte &
                                         (~n_st.ack_known | n_st.ack_high);
            end
        end
        o_result.done_res     = done;
        o_result.status       = status;
        o_result.read_data    = rd;
        o_result.ack_received = ak;
    end

    assign o_state = n_st;

endmodule

// ----- rtl/i2cmbe_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_out_reg
// Result register: holds one result until the downstream side takes it,
// and frees itself in the same cycle it is taken.
// ----------------------------------------------------------------------------
module i2cmbe_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2cmbe_pkg::t_result i_result,
    input  logic                i_ready,
    output logic                o_can_load,
    output logic                o_valid,
    output i2cmbe_pkg::t_result o_result
);

    logic                r_valid;
    i2cmbe_pkg::t_result r_result;

    assign o_can_load = ~r_valid | i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/i2cmbe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_checker
// Port-level checks of the byte engine's result stream, bound to the top.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_scl_drive_en,
    input logic       o_done_res,
    input logic [1:0] o_status,
    input logic [7:0] o_read_data,
    input logic       o_ack_received
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data) && $stable(o_status))
        else $error("stalled result changed");

    // received data only comes with a successful completion
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_read_data != 8'd0 |->
            o_done_res && o_status == i2cmbe_pkg::ST_OK && !o_ack_received)
        else $error("read data without clean completion");

    // ack flag only comes with a successful write completion
    a_ack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ack_received |->
            o_done_res && o_status == i2cmbe_pkg::ST_OK && o_read_data == 8'd0)
        else $error("ack flag without clean completion");

    // rejection for missing clock only while SCL is disabled
    a_no_scl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == i2cmbe_pkg::ST_NO_SCL |-> o_done_res && !o_scl_drive_en)
        else $error("scl rejection with scl enabled");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_scl_drive_en (o_scl_drive_en),
    .o_done_res     (o_done_res),
    .o_status       (o_status),
    .o_read_data    (o_read_data),
    .o_ack_received (o_ack_received)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the i2c master byte engine. Tick, set-lines, write and read
// requests go in under random gaps and result stalls. Every request yields one
// result, which is checked field by field against a cycle-free model of the
// engine's line sequencer kept inside this bench.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int BYTE_TICKS   = int'(i2cmbe_pkg::PH_DONE) + 1;
    localparam int RANDOM_ITEMS = 800;
    localparam int TAIL_ITEMS   = 120;
    localparam int SETTLE       = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_req_type;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic [1:0] i_line_value;
    logic [1:0] i_line_direction;
    logic       i_sda_in;
    logic       o_valid;
    logic       i_ready;
    logic       o_scl_drive_en;
    logic       o_scl_out_level;
    logic       o_sda_drive_en;
    logic       o_sda_out_level;
    logic       o_done_res;
    logic [1:0] o_status;
    logic [7:0] o_read_data;
    logic       o_ack_received;

    // engine state as the bench sees it, and results still to come
    i2cmbe_pkg::t_state  eng;
    i2cmbe_pkg::t_result pending_results[$];
    int      mismatch_count = 0;
    int      sent_count = 0;
    bit      sender_gaps = 1'b1;
    bit      receiver_stalls = 1'b1;

    i2c_master_byte_engine_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_type       (i_req_type),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_line_value     (i_line_value),
        .i_line_direction (i_line_direction),
        .i_sda_in         (i_sda_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_scl_drive_en   (o_scl_drive_en),
        .o_scl_out_level  (o_scl_out_level),
        .o_sda_drive_en   (o_sda_drive_en),
        .o_sda_out_level  (o_sda_out_level),
        .o_done_res       (o_done_res),
        .o_status         (o_status),
        .o_read_data      (o_read_data),
        .o_ack_received   (o_ack_received)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // result side stalls in bursts
    initial begin
        i_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (receiver_stalls && $urandom_range(0, 11) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    // one sequencer step: updates eng and returns the line and status result
    function automatic i2cmbe_pkg::t_result engine_step(input i2cmbe_pkg::t_request rq);
        i2cmbe_pkg::t_result r;
        r = '0;
        r.status = i2cmbe_pkg::ST_OK;
        case (rq.req_type)
            i2cmbe_pkg::REQ_TICK: begin
                if (eng.active_op != i2cmbe_pkg::OP_IDLE) begin
                    if (eng.phase < i2cmbe_pkg::PH_BITS_END) begin
                        // even phase raises scl, odd phase samples (read) or shifts (write) and lowers it
                        if (!eng.phase[0]) begin
                            eng.scl_high = 1'b1;
                        end else begin
                            if (eng.active_op == i2cmbe_pkg::OP_READ) begin
                                eng.shift_byte = {eng.shift_byte[6:0], rq.sda_in};
                            end else if (eng.phase < i2cmbe_pkg::PH_LAST_BIT) begin
                                eng.shift_byte = {eng.shift_byte[6:0], 1'b0};
                                if (eng.sda_on) eng.sda_high = eng.shift_byte[7];
                            end
                            eng.scl_high = 1'b0;
                        end
                        eng.phase = eng.phase + 1'b1;
                    end else if (eng.phase == i2cmbe_pkg::PH_ACK_HI) begin
                        eng.scl_high = 1'b1;
                        eng.phase = i2cmbe_pkg::PH_ACK_LO;
                    end else if (eng.phase == i2cmbe_pkg::PH_ACK_LO) begin
                        if (eng.active_op == i2cmbe_pkg::OP_WRITE) eng.ack_seen = !rq.sda_in;
                        eng.scl_high = 1'b0;
                        eng.phase = i2cmbe_pkg::PH_DONE;
                    end else begin
                        // completion restores the stored sda setting as ack preference
                        eng.ack_known = eng.sda_on;
                        eng.ack_high = eng.sda_high;
                        r.done_res = 1'b1;
                        if (eng.active_op == i2cmbe_pkg::OP_READ) r.read_data = eng.shift_byte;
                        else r.ack_received = eng.ack_seen;
                        eng.active_op = i2cmbe_pkg::OP_IDLE;
                        eng.phase = '0;
                    end
                end
            end
            i2cmbe_pkg::REQ_LINES: begin
                if (eng.active_op != i2cmbe_pkg::OP_IDLE) begin
                    r.status = i2cmbe_pkg::ST_BUSY;
                end else begin
                    eng.scl_on = rq.line_direction[i2cmbe_pkg::LINE_SCL];
                    eng.scl_high = rq.line_value[i2cmbe_pkg::LINE_SCL];
                    eng.sda_on = rq.line_direction[i2cmbe_pkg::LINE_SDA];
                    eng.sda_high = rq.line_value[i2cmbe_pkg::LINE_SDA];
                    eng.ack_known = eng.sda_on;
                    eng.ack_high = eng.sda_high;
                end
            end
            default: begin
                if (eng.active_op != i2cmbe_pkg::OP_IDLE) begin
                    r.done_res = 1'b1;
                    r.status = i2cmbe_pkg::ST_BUSY;
                end else if (!eng.scl_on) begin
                    r.done_res = 1'b1;
                    r.status = i2cmbe_pkg::ST_NO_SCL;
                end else if (rq.req_type == i2cmbe_pkg::REQ_WRITE) begin
                    eng.active_op = i2cmbe_pkg::OP_WRITE;
                    eng.phase = '0;
                    eng.shift_byte = rq.data_byte;
                    eng.ack_seen = 1'b0;
                    if (eng.sda_on) eng.sda_high = rq.data_byte[7];
                end else begin
                    eng.active_op = i2cmbe_pkg::OP_READ;
                    eng.phase = '0;
                    eng.shift_byte = '0;
                    eng.final_byte = rq.last_byte;
                end
            end
        endcase

        // line outputs after the step
        r.scl_drive_en = eng.scl_on;
        r.scl_out_level = eng.scl_high;
        r.sda_drive_en = eng.sda_on;
        r.sda_out_level = eng.sda_high;
        if (eng.active_op == i2cmbe_pkg::OP_WRITE && eng.phase >= i2cmbe_pkg::PH_ACK_HI) begin
            r.sda_drive_en = 1'b0;
            r.sda_out_level = 1'b1;
        end else if (eng.active_op == i2cmbe_pkg::OP_READ) begin
            if (eng.phase < i2cmbe_pkg::PH_ACK_HI) begin
                r.sda_drive_en = 1'b0;
                r.sda_out_level = 1'b1;
            end else begin
                r.sda_drive_en = 1'b1;
                if (!eng.final_byte) r.sda_out_level = 1'b0;
                else r.sda_out_level = eng.ack_known ? eng.ack_high : 1'b1;
            end
        end
        return r;
    endfunction

    // request with every field random; the builders below fix what matters
    function automatic i2cmbe_pkg::t_request rand_request();
        i2cmbe_pkg::t_request rq;
        rq.req_type = i2cmbe_pkg::t_req'(2'($urandom_range(0, 3)));
        rq.data_byte = 8'($urandom_range(0, 255));
        rq.last_byte = 1'($urandom_range(0, 1));
        rq.line_value = 2'($urandom_range(0, 3));
        rq.line_direction = 2'($urandom_range(0, 3));
        rq.sda_in = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    function automatic i2cmbe_pkg::t_request mk_tick(input logic sda);
        i2cmbe_pkg::t_request rq;
        rq = rand_request();
        rq.req_type = i2cmbe_pkg::REQ_TICK;
        rq.sda_in = sda;
        return rq;
    endfunction

    function automatic i2cmbe_pkg::t_request mk_lines(input logic [1:0] value,
                                                      input logic [1:0] dir);
        i2cmbe_pkg::t_request rq;
        rq = rand_request();
        rq.req_type = i2cmbe_pkg::REQ_LINES;
        rq.line_value = value;
        rq.line_direction = dir;
        return rq;
    endfunction

    function automatic i2cmbe_pkg::t_request mk_write(input logic [7:0] data);
        i2cmbe_pkg::t_request rq;
        rq = rand_request();
        rq.req_type = i2cmbe_pkg::REQ_WRITE;
        rq.data_byte = data;
        return rq;
    endfunction

    function automatic i2cmbe_pkg::t_request mk_read(input logic last);
        i2cmbe_pkg::t_request rq;
        rq = rand_request();
        rq.req_type = i2cmbe_pkg::REQ_READ;
        rq.last_byte = last;
        return rq;
    endfunction

    // request side gap
    task automatic hold_off(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // stop sending until every expected result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // present one request, wait for it to be taken, then predict its result
    task automatic send_request(input i2cmbe_pkg::t_request rq);
        if (sender_gaps && $urandom_range(0, 9) == 0) hold_off(int'($urandom_range(1, 16)));
        i_valid <= 1'b1;
        i_req_type <= rq.req_type;
        i_data_byte <= rq.data_byte;
        i_last_byte <= rq.last_byte;
        i_line_value <= rq.line_value;
        i_line_direction <= rq.line_direction;
        i_sda_in <= rq.sda_in;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(engine_step(rq));
        sent_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        i2cmbe_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0h done %0b", $time,
                         o_status, o_done_res);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("scl_drive_en", 8'(want.scl_drive_en), 8'(o_scl_drive_en));
                check_field("scl_out_level", 8'(want.scl_out_level), 8'(o_scl_out_level));
                check_field("sda_drive_en", 8'(want.sda_drive_en), 8'(o_sda_drive_en));
                check_field("sda_out_level", 8'(want.sda_out_level), 8'(o_sda_out_level));
                check_field("done_res", 8'(want.done_res), 8'(o_done_res));
                check_field("status", 8'(want.status), 8'(o_status));
                check_field("read_data", want.read_data, o_read_data);
                check_field("ack_received", 8'(want.ack_received), 8'(o_ack_received));
            end
        end
    end

    // idle tick and byte commands before scl is enabled
    task automatic test_idle_rules();
        send_request(mk_tick(1'b1));
        send_request(mk_write(8'h00));
        send_request(mk_read(1'b1));
        send_request(mk_lines(2'b00, 2'b00));
        send_request(mk_read(1'b0));
    endtask

    // write with sda not driven, busy command and busy set-lines mid byte
    task automatic test_write_sda_off();
        send_request(mk_lines(2'b11, 2'b01));
        send_request(mk_write(8'hFF));
        send_request(mk_read(1'b0));
        send_request(mk_lines(2'b00, 2'b00));
        for (int i = 0; i < BYTE_TICKS; i++) begin
            send_request(mk_tick(i != int'(i2cmbe_pkg::PH_ACK_LO)));
        end
    endtask

    // one byte transfer, sometimes cut short and with stray requests mixed in
    task automatic run_transfer();
        int   n_ticks;
        int   sda_mode;
        logic sda;
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 3) == 0)
                send_request(mk_lines(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))));
            else
                send_request(mk_lines(2'($urandom_range(0, 3)),
                                      {1'($urandom_range(0, 1)), 1'b1}));
        end
        if ($urandom_range(0, 1) == 1) send_request(mk_write(8'($urandom_range(0, 255))));
        else send_request(mk_read(1'($urandom_range(0, 1))));
        n_ticks = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, BYTE_TICKS + 6))
                                              : BYTE_TICKS;
        sda_mode = int'($urandom_range(0, 3));
        for (int i = 0; i < n_ticks; i++) begin
            if ($urandom_range(0, 15) == 0) send_request(rand_request());
            case (sda_mode)
                0: sda = 1'b0;
                1: sda = 1'b1;
                default: sda = 1'($urandom_range(0, 1));
            endcase
            send_request(mk_tick(sda));
        end
    endtask

    task automatic test_random_transfers(input int n_items);
        int start;
        start = sent_count;
        while (sent_count - start < n_items) run_transfer();
    endtask

    // last stretch back to back on both sides
    task automatic test_tail_no_idle();
        int start;
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        start = sent_count;
        while (sent_count - start < TAIL_ITEMS) run_transfer();
    endtask

    // main sequence
    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req_type <= i2cmbe_pkg::REQ_TICK;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        i_line_value <= '0;
        i_line_direction <= '0;
        i_sda_in <= 1'b0;
        eng = '0;
        eng.scl_high = 1'b1;
        eng.sda_high = 1'b1;
        eng.ack_high = 1'b1;
        eng.active_op = i2cmbe_pkg::OP_IDLE;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_rules();
        test_write_sda_off();
        test_random_transfers(RANDOM_ITEMS / 2);
        wait_drained();
        test_random_transfers(RANDOM_ITEMS / 2);
        test_tail_no_idle();

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
